// File: hw/rtl/sbpa_pkg.sv
package sbpa_pkg;

	localparam int CFG_POOLS = 6;
	localparam int POOL_COUNT_DEF = 6;
	localparam int MAX_SLOTS_DEF = 64;
	localparam int CNT_W = 7;
	localparam int SIZE_W = 16;
	localparam int CFG_W = 42;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNTS = 3'd6;

	localparam logic [SIZE_W-1:0] BYTES_RST [CFG_POOLS] = '{
		16'd13, 16'd133, 16'd257, 16'd529, 16'd1257, 16'd2401
	};
	localparam logic [CFG_W-1:0] SLOT_COUNTS_RST = 42'd103622511154;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] request_size;
		logic [2:0]  free_pool;
		logic [5:0]  free_slot;
		logic [2:0]  count_pool;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [2:0] grant_pool;
		logic [5:0] grant_slot;
		logic       bad_free;
		logic [6:0] used_count;
	} rsp_t;

endpackage

// File: hw/rtl/sbpa_ram.sv
module sbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/segregated_block_pool_allocator.sv
// Accept to result valid: S_RD, S_CHK (once per pool visited, 1..POOL_COUNT, on
// an allocate), S_CNT, S_DONE; a rejected free skips to S_CNT. rsp_stall can
// hold S_DONE. One word in flight; the next request is taken the cycle after
// the result register loads. Each pool visit is one read and one check of the
// pool RAM. Reset clears the per-pool valid bits (maps and counters read as
// empty), loads the configuration reset values and empties the result register.
module segregated_block_pool_allocator #(
	parameter int POOL_COUNT = sbpa_pkg::POOL_COUNT_DEF,
	parameter int MAX_SLOTS_PER_POOL = sbpa_pkg::MAX_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  sbpa_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output sbpa_pkg::rsp_t                       rsp,
	input  logic                                 cfg_we,
	input  logic [sbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbpa_pkg::CFG_W-1:0]           cfg_data
);

	import sbpa_pkg::*;

	localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int SW = (MAX_SLOTS_PER_POOL > 1) ? $clog2(MAX_SLOTS_PER_POOL) : 1;
	localparam int EW = MAX_SLOTS_PER_POOL + CNT_W;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_CNT, S_DONE} state_t;

	state_t                  state_q;
	logic [SIZE_W-1:0]       bytes_q [CFG_POOLS];
	logic [CFG_W-1:0]        counts_q;
	logic [POOL_COUNT-1:0]   valid_q;
	logic                    cmd_q;
	logic [SIZE_W-1:0]       size_q;
	logic [SW-1:0]           fslot_q;
	logic [2:0]              cpool_q;
	logic [PW-1:0]           p_q;
	logic                    granted_q;
	logic [SW-1:0]           gslot_q;
	logic                    bad_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    accept;
	logic [2:0]              lim_pool;
	logic [SIZE_W-1:0]       size_c;
	logic [CNT_W-1:0]        lim_c;
	logic [CNT_W-1:0]        lim_raw;
	logic [EW-1:0]           entry;
	logic [MAX_SLOTS_PER_POOL-1:0] map;
	logic [CNT_W-1:0]        cnt;
	logic [MAX_SLOTS_PER_POOL-1:0] free_mask;
	logic                    found;
	logic [SW-1:0]           low_idx;
	logic                    free_ok;
	logic                    cpool_ok;
	logic                    ram_we;
	logic [EW-1:0]           ram_wdata;
	logic                    ram_re;
	logic [PW-1:0]           ram_raddr;
	logic [EW-1:0]           ram_rdata;
	logic                    alloc_hit;
	logic                    free_hit;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		lim_pool = (state_q == S_IDLE) ? req.free_pool : 3'(p_q);
		size_c   = '0;
		lim_raw  = '0;
		for (int i = 0; i < CFG_POOLS; i++) begin
			if (lim_pool == 3'(i)) begin
				size_c  = bytes_q[i];
				lim_raw = counts_q[CNT_W*i +: CNT_W];
			end
		end
		lim_c = (lim_raw > CNT_W'(MAX_SLOTS_PER_POOL)) ? CNT_W'(MAX_SLOTS_PER_POOL) : lim_raw;
	end

	always_comb begin
		entry = valid_q[p_q] ? ram_rdata : '0;
		map   = entry[MAX_SLOTS_PER_POOL-1:0];
		cnt   = entry[EW-1:MAX_SLOTS_PER_POOL];
		for (int s = 0; s < MAX_SLOTS_PER_POOL; s++) begin
			free_mask[s] = !map[s] && (CNT_W'(s) < lim_c);
		end
		found   = 1'b0;
		low_idx = '0;
		for (int s = MAX_SLOTS_PER_POOL - 1; s >= 0; s--) begin
			if (free_mask[s]) begin
				found   = 1'b1;
				low_idx = SW'(s);
			end
		end
	end

	assign free_ok = ({1'b0, req.free_pool} < 4'(POOL_COUNT)) &&
		({1'b0, req.free_slot} < lim_c);
	assign cpool_ok  = ({1'b0, cpool_q} < 4'(POOL_COUNT));
	assign alloc_hit = (cmd_q == CMD_ALLOC) && (size_c >= size_q) && found;
	assign free_hit  = (cmd_q == CMD_FREE) && map[fslot_q];

	always_comb begin
		ram_we    = (state_q == S_CHK) && (alloc_hit || free_hit);
		ram_wdata = entry;
		if (cmd_q == CMD_ALLOC) begin
			ram_wdata[low_idx] = 1'b1;
			ram_wdata[EW-1:MAX_SLOTS_PER_POOL] = cnt + CNT_W'(1);
		end else begin
			ram_wdata[fslot_q] = 1'b0;
			ram_wdata[EW-1:MAX_SLOTS_PER_POOL] = cnt - CNT_W'(1);
		end
		ram_re    = (state_q == S_RD) || (state_q == S_CNT);
		ram_raddr = (state_q == S_CNT) ? PW'(cpool_q) : p_q;
	end

	sbpa_ram #(
		.WIDTH (EW),
		.DEPTH (POOL_COUNT)
	) u_pool_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (p_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q  <= BYTES_RST;
			counts_q <= SLOT_COUNTS_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_SLOT_COUNTS) begin
				counts_q <= cfg_data;
			end else begin
				for (int i = 0; i < CFG_POOLS; i++) begin
					if (cfg_index == CFG_IDX_W'(i)) begin
						bytes_q[i] <= cfg_data[SIZE_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			cmd_q       <= CMD_ALLOC;
			size_q      <= '0;
			fslot_q     <= '0;
			cpool_q     <= '0;
			p_q         <= '0;
			granted_q   <= 1'b0;
			gslot_q     <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= req.command;
						size_q    <= req.request_size;
						fslot_q   <= SW'(req.free_slot);
						cpool_q   <= req.count_pool;
						granted_q <= 1'b0;
						gslot_q   <= '0;
						if (req.command == CMD_ALLOC) begin
							bad_q   <= 1'b0;
							p_q     <= '0;
							state_q <= S_RD;
						end else if (free_ok) begin
							bad_q   <= 1'b0;
							p_q     <= PW'(req.free_pool);
							state_q <= S_RD;
						end else begin
							bad_q   <= 1'b1;
							state_q <= S_CNT;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (ram_we) begin
						valid_q[p_q] <= 1'b1;
					end
					if (cmd_q == CMD_FREE || alloc_hit) begin
						granted_q <= alloc_hit;
						gslot_q   <= low_idx;
						state_q   <= S_CNT;
					end else if (p_q == PW'(POOL_COUNT - 1)) begin
						state_q <= S_CNT;
					end else begin
						p_q     <= p_q + PW'(1);
						state_q <= S_RD;
					end
				end
				S_CNT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.granted       <= granted_q;
						rsp_q.grant_pool    <= granted_q ? 3'(p_q) : 3'd0;
						rsp_q.grant_slot    <= granted_q ? 6'(gslot_q) : 6'd0;
						rsp_q.bad_free      <= bad_q;
						rsp_q.used_count    <= (cpool_ok && valid_q[PW'(cpool_q)]) ?
							ram_rdata[EW-1:MAX_SLOTS_PER_POOL] : '0;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/tb_segregated_block_pool_allocator.sv
`timescale 1ns / 100ps

module tb_segregated_block_pool_allocator;
	import sbpa_pkg::*;

	localparam int POOLS = POOL_COUNT_DEF;
	localparam int SLOTS = MAX_SLOTS_DEF;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	segregated_block_pool_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	req_t pending_req[$];
	rsp_t expected_rsp[$];
	rsp_t want_rsp;
	int errors = 0;
	logic word_taken = 1'b0;

	// pool model state
	logic [SIZE_W-1:0] pool_bytes [POOLS];
	logic [CFG_W-1:0] slot_counts;
	logic [63:0] used_map [POOLS];
	logic [CNT_W-1:0] used_cnt [POOLS];

	// generator's view of the configuration
	logic [SIZE_W-1:0] gen_bytes [CFG_POOLS];
	logic [CFG_W-1:0] gen_counts;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int clamp_count(logic [CFG_W-1:0] counts, int p);
		int c;
		if (p >= CFG_POOLS)
			return 0;
		c = counts[7*p +: 7];
		return (c > SLOTS) ? SLOTS : c;
	endfunction

	function automatic rsp_t apply_pool_op(req_t r);
		rsp_t o;
		int lim;
		o = '0;
		if (r.command == CMD_ALLOC) begin
			for (int p = 0; p < POOLS && !o.granted; p++) begin
				if (pool_bytes[p] >= r.request_size) begin
					lim = clamp_count(slot_counts, p);
					for (int s = 0; s < lim && !o.granted; s++) begin
						if (!used_map[p][s]) begin
							used_map[p][s] = 1'b1;
							used_cnt[p] = used_cnt[p] + 1'b1;
							o.granted = 1'b1;
							o.grant_pool = 3'(p);
							o.grant_slot = 6'(s);
						end
					end
				end
			end
		end else if (r.free_pool >= POOLS ||
				r.free_slot >= clamp_count(slot_counts, r.free_pool)) begin
			o.bad_free = 1'b1;
		end else if (used_map[r.free_pool][r.free_slot]) begin
			used_map[r.free_pool][r.free_slot] = 1'b0;
			used_cnt[r.free_pool] = used_cnt[r.free_pool] - 1'b1;
		end
		if (r.count_pool < POOLS)
			o.used_count = used_cnt[r.count_pool];
		return o;
	endfunction

	always @(posedge clk) begin
		word_taken = req_valid && !req_stall;
		if (!arst_n) begin
			for (int p = 0; p < POOLS; p++) begin
				pool_bytes[p] = BYTES_RST[p];
				used_map[p] = '0;
				used_cnt[p] = '0;
			end
			slot_counts = SLOT_COUNTS_RST;
		end else begin
			if (cfg_we) begin
				if (cfg_index < CFG_POOLS)
					pool_bytes[cfg_index] = cfg_data[SIZE_W-1:0];
				else if (cfg_index == CFG_SLOT_COUNTS)
					slot_counts = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t unexpected word: granted=%0d pool=%0d slot=%0d bad=%0d used=%0d",
						$realtime, rsp.granted, rsp.grant_pool, rsp.grant_slot,
						rsp.bad_free, rsp.used_count);
				end else begin
					want_rsp = expected_rsp.pop_front();
					if (rsp !== want_rsp) begin
						errors++;
						$display("%0t mismatch: expected granted=%0d pool=%0d slot=%0d bad=%0d used=%0d",
							$realtime, want_rsp.granted, want_rsp.grant_pool,
							want_rsp.grant_slot, want_rsp.bad_free, want_rsp.used_count);
						$display("%0t           got granted=%0d pool=%0d slot=%0d bad=%0d used=%0d",
							$realtime, rsp.granted, rsp.grant_pool, rsp.grant_slot,
							rsp.bad_free, rsp.used_count);
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_pool_op(req));
		end
	end

	// sender: bursts with gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!(req_valid && !word_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_req.size() != 0) begin
				req <= pending_req.pop_front();
				req_valid <= 1'b1;
				if (burst_left == 0)
					burst_left = $urandom_range(1, 24);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: stall modes of random length
	int stall_mode = 0;
	int mode_left = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 80);
		end
		mode_left--;
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= $urandom_range(0, 1);
			default: rsp_stall <= ($urandom_range(0, 4) != 0);
		endcase
	end

	task automatic push_alloc(int size, int cpool);
		req_t r;
		r = '0;
		r.command = CMD_ALLOC;
		r.request_size = 16'(size);
		r.free_pool = 3'($urandom_range(0, 7));
		r.free_slot = 6'($urandom_range(0, 63));
		r.count_pool = 3'(cpool);
		pending_req.push_back(r);
	endtask

	task automatic push_free(int pool, int slot, int cpool);
		req_t r;
		r = '0;
		r.command = CMD_FREE;
		r.request_size = 16'($urandom_range(0, 65535));
		r.free_pool = 3'(pool);
		r.free_slot = 6'(slot);
		r.count_pool = 3'(cpool);
		pending_req.push_back(r);
	endtask

	function automatic req_t random_word(int alloc_pct);
		req_t r;
		int lim;
		int k;
		r.command = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
		case ($urandom_range(0, 9))
			0, 1: r.request_size = 16'($urandom_range(0, 65535));
			2: r.request_size = '0;
			3: r.request_size = '1;
			default: begin
				k = $urandom_range(0, CFG_POOLS - 1);
				r.request_size = gen_bytes[k] + 16'($urandom_range(0, 2)) - 16'd1;
			end
		endcase
		r.free_pool = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		lim = clamp_count(gen_counts, r.free_pool);
		if (lim > 0 && $urandom_range(0, 99) < 85)
			r.free_slot = 6'($urandom_range(0, lim - 1));
		else
			r.free_slot = 6'($urandom_range(0, 63));
		r.count_pool = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		return r;
	endfunction

	task automatic wait_idle();
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_pools(int b[CFG_POOLS], int c[CFG_POOLS]);
		logic [CFG_W-1:0] packed_counts;
		packed_counts = '0;
		for (int p = 0; p < CFG_POOLS; p++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(p);
			cfg_data <= CFG_W'(b[p]);
			gen_bytes[p] = 16'(b[p]);
			packed_counts[7*p +: 7] = 7'(c[p]);
		end
		@(negedge clk);
		cfg_index <= CFG_SLOT_COUNTS;
		cfg_data <= packed_counts;
		gen_counts = packed_counts;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int b[CFG_POOLS];
		int c[CFG_POOLS];
		int pct;
		for (int p = 0; p < CFG_POOLS; p++)
			gen_bytes[p] = BYTES_RST[p];
		gen_counts = SLOT_COUNTS_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: bytes 13..2401, counts 50,20,8,3,2,3
		push_alloc(0, 0);
		push_alloc(13, 0);
		push_alloc(14, 1);
		push_alloc(2401, 5);
		push_alloc(2402, 5);
		push_alloc(65535, 2);
		repeat (4) push_alloc(529, 3);
		push_alloc(529, 4);
		push_free(3, 1, 3);
		push_free(3, 1, 3);
		push_free(3, 3, 3);
		push_free(6, 0, 6);
		push_free(7, 63, 7);
		push_free(0, 63, 0);
		push_free(0, 49, 0);
		push_free(0, 0, 0);
		repeat (3) push_alloc(2401, 5);
		push_free(5, 2, 5);
		push_alloc(257, 2);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			for (int p = 0; p < CFG_POOLS; p++) begin
				b[p] = $urandom_range(0, 65535);
				c[p] = $urandom_range(0, 127);
			end
			case (ph)
				0: begin
					b = '{8, 16, 32, 64, 128, 256};
					c = '{2, 3, 4, 1, 2, 8};
					pct = 70;
				end
				1: begin
					b[0] = 0;
					b[5] = 65535;
					c = '{0, 64, 127, 5, 1, 100};
					pct = 60;
				end
				2: begin
					b = '{65535, 65535, 65535, 65535, 65535, 65535};
					c = '{127, 127, 127, 127, 127, 127};
					pct = 80;
				end
				3: begin
					// lowered below slots still in use
					c = '{3, 1, 2, 0, 4, 2};
					pct = 30;
				end
				4: pct = 50;
				5: begin
					b = '{4000, 2000, 1000, 500, 100, 10};
					c = '{4, 4, 4, 4, 4, 4};
					pct = 60;
				end
				6: begin
					b = '{0, 0, 0, 0, 0, 0};
					c = '{64, 64, 64, 64, 64, 64};
					pct = 50;
				end
				default: pct = 40;
			endcase
			write_pools(b, c);
			repeat (94) pending_req.push_back(random_word(pct));
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
